// ===== sv/agfp_pkg.sv =====
package agfp_pkg;

    // field widths
    localparam int IV_W       = 37;
    localparam int ACT_W      = 3;
    localparam int TS_W       = 64;
    localparam int TIME_W_DEF = 64;

    // longest interval and longest wait, in ns
    localparam logic [IV_W-1:0] MAX_INTERVAL = 37'd100000000000;

    // event commands
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_DONE  = 1'b1;

    // result action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_CLEARED  = 3'd0,
        ACT_RESTART  = 3'd1,
        ACT_LATE     = 3'd2,
        ACT_WAIT     = 3'd3,
        ACT_REANCHOR = 3'd4,
        ACT_ONGRID   = 3'd5,
        ACT_IGNORED  = 3'd6
    } t_action;

    // one input event
    typedef struct packed {
        logic            cmd;
        logic            active;
        logic [TS_W-1:0] time_ns;
    } t_event;

    // one result word
    typedef struct packed {
        logic [IV_W-1:0] wait_ns;
        t_action         action;
    } t_result;

endpackage

// ===== sv/agfp_event_if.sv =====
interface agfp_event_if
    import agfp_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            cmd;
    logic            active;
    logic [TS_W-1:0] time_ns;

    modport source (output valid, output cmd, output active, output time_ns, input ready);
    modport sink   (input valid, input cmd, input active, input time_ns, output ready);
endinterface

// ===== sv/agfp_result_if.sv =====
interface agfp_result_if
    import agfp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IV_W-1:0]  wait_ns;
    logic [ACT_W-1:0] action;

    modport source (output valid, output wait_ns, output action, input ready);
    modport sink   (input valid, input wait_ns, input action, output ready);
endinterface

// ===== sv/agfp_core.sv =====
module agfp_core
    import agfp_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_W_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  t_event          i_event,
    input  logic [IV_W-1:0] i_interval_ns,
    output t_result         o_result
);

    localparam int IV2_W = IV_W + 1;
    localparam int IV3_W = IV_W + 2;

    logic [TIME_WIDTH-1:0] r_next_deadline, n_next_deadline;
    logic [IV_W-1:0]       r_grid_interval, n_grid_interval;
    logic                  r_wait_pending, n_wait_pending;

    logic [TIME_WIDTH-1:0] now;
    logic [IV_W-1:0]       iv;
    logic [IV2_W-1:0]      iv2;
    logic [IV3_W-1:0]      iv3;
    logic [IV_W-1:0]       quarter;
    logic [TIME_WIDTH-1:0] quarter_t;
    logic [TIME_WIDTH-1:0] lim;
    logic                  over;
    logic [TIME_WIDTH-1:0] late_by;
    logic [TIME_WIDTH-1:0] early_by;
    logic                  have, changed, stalled, is_late;
    logic [TIME_WIDTH-1:0] base;
    logic [IV3_W-1:0]      addend;
    logic [TIME_WIDTH-1:0] wait_full;
    logic                  upd_deadline;

    // event time at the grid width, effective interval
    assign now     = i_event.time_ns[TIME_WIDTH-1:0];
    assign iv      = (i_interval_ns > MAX_INTERVAL) ? MAX_INTERVAL : i_interval_ns;
    assign iv2     = {iv, 1'b0};
    assign iv3     = IV3_W'(iv2) + IV3_W'(iv);

    // overshoot test on completion
    assign quarter   = r_grid_interval >> 2;
    assign quarter_t = TIME_WIDTH'(quarter);
    assign lim       = r_next_deadline - quarter_t;
    assign over      = (r_next_deadline < quarter_t) || (now > lim);

    // frame position against the grid
    assign late_by  = now - r_next_deadline;
    assign early_by = r_next_deadline - now;
    assign have     = r_grid_interval != '0;
    assign changed  = r_grid_interval != iv;
    assign is_late  = now >= r_next_deadline;
    assign stalled  = have && (now > r_next_deadline) && (late_by > TIME_WIDTH'(iv2));
    assign wait_full = (early_by > TIME_WIDTH'(MAX_INTERVAL)) ? TIME_WIDTH'(MAX_INTERVAL)
                                                              : early_by;

    // decision and next state
    always_comb begin
        n_next_deadline = r_next_deadline;
        n_grid_interval = r_grid_interval;
        n_wait_pending  = r_wait_pending;
        base            = r_next_deadline;
        addend          = IV3_W'(iv);
        upd_deadline    = 1'b0;
        o_result.wait_ns = '0;
        o_result.action  = ACT_IGNORED;
        if (i_event.cmd == CMD_DONE) begin
            if (r_wait_pending && have) begin
                n_wait_pending = 1'b0;
                if (over) begin
                    base            = now;
                    addend          = IV3_W'(r_grid_interval);
                    upd_deadline    = 1'b1;
                    o_result.action = ACT_REANCHOR;
                end else begin
                    o_result.action = ACT_ONGRID;
                end
            end
        end else if (!i_event.active || (i_interval_ns == '0)) begin
            n_next_deadline = '0;
            n_grid_interval = '0;
            n_wait_pending  = 1'b0;
            o_result.action = ACT_CLEARED;
        end else if (!have || changed || stalled) begin
            n_wait_pending  = 1'b0;
            n_grid_interval = iv;
            base            = now;
            upd_deadline    = 1'b1;
            o_result.action = ACT_RESTART;
        end else if (is_late) begin
            // late by at most two intervals here: one to three steps
            n_wait_pending = 1'b0;
            if (late_by < TIME_WIDTH'(iv)) begin
                addend = IV3_W'(iv);
            end else if (late_by < TIME_WIDTH'(iv2)) begin
                addend = IV3_W'(iv2);
            end else begin
                addend = iv3;
            end
            upd_deadline    = 1'b1;
            o_result.action = ACT_LATE;
        end else begin
            n_wait_pending   = 1'b1;
            upd_deadline     = 1'b1;
            o_result.wait_ns = wait_full[IV_W-1:0];
            o_result.action  = ACT_WAIT;
        end
        if (upd_deadline) begin
            n_next_deadline = base + TIME_WIDTH'(addend);
        end
    end

    // grid state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_deadline <= '0;
            r_grid_interval <= '0;
            r_wait_pending  <= 1'b0;
        end else if (i_step) begin
            r_next_deadline <= n_next_deadline;
            r_grid_interval <= n_grid_interval;
            r_wait_pending  <= n_wait_pending;
        end
    end

endmodule

// ===== sv/absolute_grid_frame_pacer_top.sv =====
// channel   dir  words                        handshake
// i_event   in   cmd, active, time_ns         valid/ready
// o_result  out  wait_ns, action              valid/ready
// cfg       in   interval_ns                  i_cfg_we, no ready
//
// one word per cycle while the result side is not stalled; a word passes the input register, then the result register
// the grid state updates in the cycle a word moves from the input to the result register
// reset clears the grid, the interval register and both valid flags
// a stalled result register holds the input register; input ready drops only then
module absolute_grid_frame_pacer_top
    import agfp_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_W_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [IV_W-1:0] i_cfg_wdata,
    agfp_event_if.sink      i_event,
    agfp_result_if.source   o_result
);

    logic [IV_W-1:0] r_interval_ns;
    logic            r_in_valid;
    t_event          r_in;
    logic            r_out_valid;
    t_result         r_out;
    logic            out_free;
    logic            step;
    t_result         core_result;

    // handshake
    assign out_free      = !r_out_valid || o_result.ready;
    assign step          = r_in_valid && out_free;
    assign i_event.ready = !r_in_valid || out_free;

    // interval register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval_ns <= '0;
        end else if (i_cfg_we) begin
            r_interval_ns <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_event.ready) begin
            r_in_valid <= i_event.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_event.ready && i_event.valid) begin
            r_in.cmd     <= i_event.cmd;
            r_in.active  <= i_event.active;
            r_in.time_ns <= i_event.time_ns;
        end
    end

    agfp_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_event       (r_in),
        .i_interval_ns (r_interval_ns),
        .o_result      (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_result;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.wait_ns = r_out.wait_ns;
    assign o_result.action  = r_out.action;

    // a wait is only issued ahead of the deadline, so it is never zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action == ACT_WAIT) |-> (r_out.wait_ns != '0))
        else $error("wait issued with zero length");

    // only a wait result carries a wait length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action != ACT_WAIT) |-> (r_out.wait_ns == '0))
        else $error("wait length on a non-wait result");

    // a word in the input register is kept while the result side is blocked
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in)))
        else $error("input word lost under stall");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import agfp_pkg::*;

    localparam int RAND_ITEMS  = 312;
    localparam int NUM_PHASES  = 6;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 80;

    // grid predictor and result queue
    class pacer_scoreboard;
        logic [IV_W-1:0] interval_reg;
        logic [TS_W-1:0] deadline;
        logic [IV_W-1:0] grid_iv;
        bit              wait_due;
        t_result         pending_outcomes[$];
        int              errors;
        int              events_seen;
        int              results_seen;
        int              action_hits[7];

        function new();
            interval_reg = '0;
            deadline     = '0;
            grid_iv      = '0;
            wait_due     = 1'b0;
            errors       = 0;
            events_seen  = 0;
            results_seen = 0;
            foreach (action_hits[k]) action_hits[k] = 0;
        endfunction

        function void take_interval(logic [IV_W-1:0] v);
            interval_reg = v;
        endfunction

        // next grid state and the word the block should return
        function t_result pace_step(logic cmd, logic active, logic [TS_W-1:0] now);
            t_result         r;
            logic [IV_W-1:0] iv;
            logic [IV_W-1:0] q;
            logic [TS_W-1:0] gap;
            logic [TS_W-1:0] ahead;
            logic [TS_W-1:0] steps;
            bit              over;
            bit              stalled;
            r.wait_ns = '0;
            r.action  = ACT_IGNORED;
            // completion of an issued wait
            if (cmd == CMD_DONE) begin
                if (!wait_due || grid_iv == 0) return r;
                wait_due = 1'b0;
                q = grid_iv >> 2;
                over = (deadline >= q) ? (now > deadline - q) : 1'b1;
                if (over) begin
                    deadline = now + grid_iv;
                    r.action = ACT_REANCHOR;
                end else begin
                    r.action = ACT_ONGRID;
                end
                return r;
            end
            // pacing off clears the grid
            if (!active || interval_reg == 0) begin
                deadline = '0;
                grid_iv  = '0;
                wait_due = 1'b0;
                r.action = ACT_CLEARED;
                return r;
            end
            iv = (interval_reg > MAX_INTERVAL) ? MAX_INTERVAL : interval_reg;
            stalled = (grid_iv != 0) && (now > deadline) && ((now - deadline) > {iv, 1'b0});
            wait_due = 1'b0;
            // first frame, new interval or long stall
            if (grid_iv == 0 || grid_iv != iv || stalled) begin
                deadline = now + iv;
                grid_iv  = iv;
                r.action = ACT_RESTART;
                return r;
            end
            // late frame skips ahead without waiting
            if (now >= deadline) begin
                gap   = now - deadline;
                steps = gap / iv + 1;
                if (steps > 3) steps = 3;
                deadline = deadline + steps * iv;
                r.action = ACT_LATE;
                return r;
            end
            // early frame waits for its deadline
            ahead = deadline - now;
            if (ahead > MAX_INTERVAL) ahead = MAX_INTERVAL;
            deadline  = deadline + iv;
            wait_due  = 1'b1;
            r.wait_ns = ahead[IV_W-1:0];
            r.action  = ACT_WAIT;
            return r;
        endfunction

        function void note_event(logic cmd, logic active, logic [TS_W-1:0] now);
            events_seen++;
            pending_outcomes.push_back(pace_step(cmd, active, now));
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40) $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        task check_result(logic [IV_W-1:0] w, logic [ACT_W-1:0] a);
            t_result want;
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                report_mismatch($sformatf("unexpected word: action %0d wait_ns %0d", a, w));
                return;
            end
            want = pending_outcomes.pop_front();
            action_hits[want.action]++;
            if (a !== want.action)
                report_mismatch($sformatf("word %0d: action %0d, want %0d",
                                          results_seen, a, want.action));
            if (w !== want.wait_ns)
                report_mismatch($sformatf("word %0d: wait_ns %0d, want %0d",
                                          results_seen, w, want.wait_ns));
        endtask
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            cfg_we;
    logic [IV_W-1:0] cfg_wdata;
    int              send_idle;
    int              recv_idle;
    logic [TS_W-1:0] cur_time;
    int              quiet_cycles;
    int              settings_done;
    bit              held;

    pacer_scoreboard sb = new();

    agfp_event_if  evt_ch ();
    agfp_result_if res_ch ();

    absolute_grid_frame_pacer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_event     (evt_ch),
        .o_result    (res_ch)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // monitor: register writes, accepted events and results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_we) sb.take_interval(cfg_wdata);
            if (evt_ch.valid && evt_ch.ready)
                sb.note_event(evt_ch.cmd, evt_ch.active, evt_ch.time_ns);
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.wait_ns, res_ch.action);
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (evt_ch.valid && evt_ch.ready) ||
            (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side ready, with one long hold-off to back up the pipe
    initial begin
        res_ch.ready = 1'b0;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held && sb.results_seen >= 150) begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    function automatic logic [63:0] rand_upto(logic [63:0] n);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return (n == '1) ? r : r % (n + 1);
    endfunction

    function automatic logic [IV_W-1:0] phase_interval(int p);
        case (p)
            0:       return 37'd1000;
            1:       return '1;
            2:       return MAX_INTERVAL;
            3:       return 37'd3;
            4:       return 37'd16666667;
            default: return IV_W'($urandom_range(1, 1 << 20));
        endcase
    endfunction

    // offer one word and hold it until taken
    task automatic offer_event(logic cmd, logic active, logic [TS_W-1:0] t);
        while ($urandom_range(99) < send_idle) begin
            evt_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        evt_ch.valid   <= 1'b1;
        evt_ch.cmd     <= cmd;
        evt_ch.active  <= active;
        evt_ch.time_ns <= t;
        @(posedge i_clk);
        while (!evt_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // register write once the pipe has drained
    task automatic set_interval(logic [IV_W-1:0] v);
        evt_ch.valid <= 1'b0;
        while (sb.pending_outcomes.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        settings_done++;
    endtask

    // mostly paced frame streams with completions, plus some noise
    task automatic random_event(logic [63:0] iv);
        int unsigned pick;
        logic [63:0] t;
        pick = $urandom_range(99);
        if (pick < 5) begin
            offer_event(CMD_FRAME, 1'b0, cur_time);
        end else if (pick < 9) begin
            t = rand_upto('1);
            cur_time = t;
            offer_event(1'($urandom_range(1)), 1'($urandom_range(1)), t);
        end else if (pick < 34 && sb.wait_due) begin
            // completion around the deadline that was waited for
            t = sb.deadline - sb.grid_iv - (iv >> 3) + rand_upto(iv);
            cur_time = t;
            offer_event(CMD_DONE, 1'($urandom_range(1)), t);
        end else if (pick >= 34 && pick < 38) begin
            offer_event(CMD_DONE, 1'($urandom_range(1)), cur_time);
        end else if (pick >= 38 && pick < 42 && sb.grid_iv != 0) begin
            // right at the stall boundary
            t = sb.deadline + 2 * sb.grid_iv + $urandom_range(1);
            cur_time = t;
            offer_event(CMD_FRAME, 1'b1, t);
        end else begin
            cur_time = cur_time + ((pick < 90) ? rand_upto(iv * 5 / 2) : rand_upto(iv * 4));
            offer_event(CMD_FRAME, 1'b1, cur_time);
        end
    endtask

    // stimulus
    initial begin
        logic [63:0] step_iv;
        logic [IV_W-1:0] piv;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        evt_ch.valid   = 1'b0;
        evt_ch.cmd     = CMD_FRAME;
        evt_ch.active  = 1'b0;
        evt_ch.time_ns = '0;
        send_idle      = 38;
        recv_idle      = 88;
        cur_time       = '0;
        quiet_cycles   = 0;
        settings_done  = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: interval zero after reset
        offer_event(CMD_FRAME, 1'b1, 64'd100);
        offer_event(CMD_DONE, 1'b0, 64'd200);
        set_interval(37'd1000);
        offer_event(CMD_FRAME, 1'b0, 64'd5000);
        offer_event(CMD_FRAME, 1'b1, 64'd0);
        offer_event(CMD_FRAME, 1'b1, 64'd400);
        offer_event(CMD_DONE, 1'b1, 64'd650);
        offer_event(CMD_DONE, 1'b1, 64'd700);
        // frame while a wait is pending
        offer_event(CMD_FRAME, 1'b1, 64'd1500);
        offer_event(CMD_FRAME, 1'b1, 64'd2100);
        // late by one step, then by exactly two intervals
        offer_event(CMD_FRAME, 1'b1, 64'd4000);
        offer_event(CMD_FRAME, 1'b1, 64'd7000);
        // stall just past two intervals
        offer_event(CMD_FRAME, 1'b1, 64'd10001);
        offer_event(CMD_FRAME, 1'b1, 64'd10500);
        offer_event(CMD_DONE, 1'b0, 64'd11900);
        // deadline wraps through zero, overshoot with deadline under a quarter
        offer_event(CMD_FRAME, 1'b1, 64'hFFFF_FFFF_FFFF_F830);
        offer_event(CMD_FRAME, 1'b1, 64'hFFFF_FFFF_FFFF_FA24);
        offer_event(CMD_DONE, 1'b1, 64'hFFFF_FFFF_FFFF_FC7C);
        offer_event(CMD_FRAME, 1'b1, 64'd50);
        // oversized interval saturates, long wait saturates
        set_interval('1);
        offer_event(CMD_FRAME, 1'b1, 64'd123);
        offer_event(CMD_FRAME, 1'b1, 64'd0);
        set_interval(37'd1);
        offer_event(CMD_FRAME, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
        offer_event(CMD_FRAME, 1'b1, 64'h5555_5555_5555_5555);
        offer_event(CMD_FRAME, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);

        // random phases over several intervals and idle patterns
        for (int p = 0; p < NUM_PHASES; p++) begin
            piv = phase_interval(p);
            set_interval(piv);
            case (p / 2)
                0: begin send_idle = 38; recv_idle = 88; end
                1: begin send_idle = 88; recv_idle = 38; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            step_iv = (piv > MAX_INTERVAL) ? MAX_INTERVAL : piv;
            cur_time = (p % 2) ? ('1 - step_iv * 64) : (rand_upto('1) >> 1);
            for (int n = 0; n < RAND_ITEMS; n++) random_event(step_iv);
        end

        // drain and settle
        evt_ch.valid <= 1'b0;
        while (sb.pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (sb.pending_outcomes.size() != 0)
            sb.report_mismatch($sformatf("%0d words never arrived", sb.pending_outcomes.size()));

        $display("run: %0d events, %0d words, %0d interval settings, %0d mismatches",
                 sb.events_seen, sb.results_seen, settings_done, sb.errors);
        $display("outcomes: cleared %0d restart %0d late %0d wait %0d re-anchor %0d %s %0d %s %0d",
                 sb.action_hits[ACT_CLEARED], sb.action_hits[ACT_RESTART],
                 sb.action_hits[ACT_LATE], sb.action_hits[ACT_WAIT],
                 sb.action_hits[ACT_REANCHOR], "on-grid", sb.action_hits[ACT_ONGRID],
                 "ignored", sb.action_hits[ACT_IGNORED]);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== absolute_grid_frame_pacer_top.f =====
sv/agfp_pkg.sv
sv/agfp_event_if.sv
sv/agfp_result_if.sv
sv/agfp_core.sv
sv/absolute_grid_frame_pacer_top.sv
tb/sv/tb_top.sv
